### sv/rbi_pkg.sv
// Shared types, widths and codes of the ray against box intersection block.
package rbi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CRD_W         = 32;
	localparam int EDGE_W        = 31;
	localparam int T_W           = 48;
	localparam int N_W           = 34;
	localparam int NMAG_W        = 33;
	localparam int DMAG_W        = 32;
	localparam int NAXES         = 3;
	localparam int NFACES        = 6;
	localparam int CFG_IDX_W     = 2;
	localparam int FRONT_STAGES  = 4;

	localparam logic [EDGE_W-1:0] EDGE_RST = 31'd65536;

	typedef logic signed [CRD_W-1:0] crd_t;
	typedef logic [EDGE_W-1:0]       edge_t;
	typedef logic signed [N_W-1:0]   n_t;

	typedef enum logic [2:0] {
		ST_MISS     = 3'd0,
		ST_HIT      = 3'd1,
		ST_SINGLE   = 3'd2,
		ST_MANY     = 3'd3,
		ST_ZERO_DIR = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EDGE_X = 2'd0,
		REG_EDGE_Y = 2'd1,
		REG_EDGE_Z = 2'd2
	} reg_idx_t;

	// Faces in test order: z then x then y, positive face first.
	localparam int FACE_AXIS [NFACES] = '{2, 2, 0, 0, 1, 1};
	localparam int FACE_SIDE [NFACES] = '{0, 1, 0, 1, 0, 1};

	// Two faces picked for division, with the classification.
	typedef struct packed {
		status_t status;
		n_t      n0;
		crd_t    d0;
		n_t      n1;
		crd_t    d1;
	} div_req_t;

	// j-th axis other than a.
	function automatic int other_axis(input int a, input int j);
		int s;
		s = a + j + 1;
		return (s >= NAXES) ? s - NAXES : s;
	endfunction

endpackage

### sv/rbi_front.sv
// Face tests: numerators, cross products, inside compares and hit selection in four stages.
module rbi_front (
	input  logic             clk,
	input  logic [3:0]       en,
	input  rbi_pkg::edge_t   edge_len [rbi_pkg::NAXES],
	input  rbi_pkg::crd_t    pos      [rbi_pkg::NAXES],
	input  rbi_pkg::crd_t    dir      [rbi_pkg::NAXES],
	output rbi_pkg::div_req_t req
);

	// stage 1
	rbi_pkg::crd_t p_s1 [rbi_pkg::NAXES];
	rbi_pkg::crd_t d_s1 [rbi_pkg::NAXES];
	logic [rbi_pkg::DMAG_W-1:0] dm_s1 [rbi_pkg::NAXES];
	rbi_pkg::n_t   n_s1 [rbi_pkg::NAXES][2];
	logic          zdir_s1;
	rbi_pkg::n_t   n_c  [rbi_pkg::NAXES][2];

	// stage 2
	logic signed [64:0] a_s2 [rbi_pkg::NAXES][2];
	logic signed [65:0] q_s2 [rbi_pkg::NAXES][2][2];
	logic [62:0]        b_s2 [rbi_pkg::NAXES][2];
	rbi_pkg::n_t        n_s2 [rbi_pkg::NAXES][2];
	rbi_pkg::crd_t      d_s2 [rbi_pkg::NAXES];
	logic               zdir_s2;

	// stage 3
	logic          hit_s3  [rbi_pkg::NAXES][2];
	rbi_pkg::n_t   n_s3    [rbi_pkg::NAXES][2];
	rbi_pkg::crd_t d_s3    [rbi_pkg::NAXES];
	logic          zdir_s3;
	logic          hit_c   [rbi_pkg::NAXES][2];

	rbi_pkg::div_req_t req_c;

	always_comb begin
		logic [rbi_pkg::N_W-1:0] p2;
		logic [rbi_pkg::N_W-1:0] e_w;
		for (int a = 0; a < rbi_pkg::NAXES; a++) begin
			p2  = {pos[a][rbi_pkg::CRD_W-1], pos[a], 1'b0};
			e_w = {3'b000, edge_len[a]};
			n_c[a][0] = e_w - p2;
			n_c[a][1] = (~e_w + 1'b1) - p2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int a = 0; a < rbi_pkg::NAXES; a++) begin
				p_s1[a]    <= pos[a];
				d_s1[a]    <= dir[a];
				dm_s1[a]   <= dir[a][rbi_pkg::CRD_W-1] ? rbi_pkg::DMAG_W'(-dir[a])
				                                       : rbi_pkg::DMAG_W'(dir[a]);
				n_s1[a][0] <= n_c[a][0];
				n_s1[a][1] <= n_c[a][1];
			end
			zdir_s1 <= (dir[0] == '0) && (dir[1] == '0) && (dir[2] == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int a = 0; a < rbi_pkg::NAXES; a++) begin
				for (int j = 0; j < 2; j++) begin
					a_s2[a][j]    <= $signed({p_s1[rbi_pkg::other_axis(a, j)], 1'b0}) * d_s1[a];
					q_s2[a][j][0] <= d_s1[rbi_pkg::other_axis(a, j)] * n_s1[a][0];
					q_s2[a][j][1] <= d_s1[rbi_pkg::other_axis(a, j)] * n_s1[a][1];
					b_s2[a][j]    <= edge_len[rbi_pkg::other_axis(a, j)] * dm_s1[a];
				end
				n_s2[a][0] <= n_s1[a][0];
				n_s2[a][1] <= n_s1[a][1];
				d_s2[a]    <= d_s1[a];
			end
			zdir_s2 <= zdir_s1;
		end
	end

	// Hit point strictly inside the face rectangle on both other axes.
	always_comb begin
		logic signed [66:0] s;
		logic [66:0]        m;
		logic               ok;
		for (int a = 0; a < rbi_pkg::NAXES; a++) begin
			for (int f = 0; f < 2; f++) begin
				ok = (d_s2[a] != '0);
				for (int j = 0; j < 2; j++) begin
					s  = a_s2[a][j] + q_s2[a][j][f];
					m  = s[66] ? 67'(-s) : 67'(s);
					ok = ok && (m < {4'b0000, b_s2[a][j]});
				end
				hit_c[a][f] = ok;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int a = 0; a < rbi_pkg::NAXES; a++) begin
				hit_s3[a][0] <= hit_c[a][0];
				hit_s3[a][1] <= hit_c[a][1];
				n_s3[a][0]   <= n_s2[a][0];
				n_s3[a][1]   <= n_s2[a][1];
				d_s3[a]      <= d_s2[a];
			end
			zdir_s3 <= zdir_s2;
		end
	end

	// Count hits and pick the first two in test order.
	always_comb begin
		logic [2:0] cnt;
		cnt   = 3'd0;
		req_c = '0;
		for (int i = 0; i < rbi_pkg::NFACES; i++) begin
			if (hit_s3[rbi_pkg::FACE_AXIS[i]][rbi_pkg::FACE_SIDE[i]]) begin
				if (cnt == 3'd0) begin
					req_c.n0 = n_s3[rbi_pkg::FACE_AXIS[i]][rbi_pkg::FACE_SIDE[i]];
					req_c.d0 = d_s3[rbi_pkg::FACE_AXIS[i]];
				end else if (cnt == 3'd1) begin
					req_c.n1 = n_s3[rbi_pkg::FACE_AXIS[i]][rbi_pkg::FACE_SIDE[i]];
					req_c.d1 = d_s3[rbi_pkg::FACE_AXIS[i]];
				end
				if (cnt != 3'd3) begin
					cnt = cnt + 3'd1;
				end
			end
		end
		if (zdir_s3) begin
			req_c.status = rbi_pkg::ST_ZERO_DIR;
		end else begin
			case (cnt)
				3'd0:    req_c.status = rbi_pkg::ST_MISS;
				3'd1:    req_c.status = rbi_pkg::ST_SINGLE;
				3'd2:    req_c.status = rbi_pkg::ST_HIT;
				default: req_c.status = rbi_pkg::ST_MANY;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			req <= req_c;
		end
	end

endmodule

### sv/rbi_div.sv
// Two-lane pipelined restoring divider for t, one quotient bit per stage.
module rbi_div #(
	parameter int FRAC_BITS = rbi_pkg::FRAC_BITS_DEF,
	parameter int DW        = rbi_pkg::NMAG_W + FRAC_BITS - 1
) (
	input  logic              clk,
	input  logic [DW-1:0]     en,
	input  rbi_pkg::div_req_t req,
	output rbi_pkg::status_t  status,
	output logic signed [DW:0] t0,
	output logic signed [DW:0] t1
);

	localparam int RW = rbi_pkg::DMAG_W + 1;
	localparam int WW = RW + DW;

	logic [WW-1:0]              w_in   [2];
	logic [rbi_pkg::DMAG_W-1:0] dv_in  [2];
	logic                       neg_in [2];

	logic [WW-1:0]              w_sd   [DW][2];
	logic [rbi_pkg::DMAG_W-1:0] dv_sd  [DW][2];
	logic                       neg_sd [DW][2];
	rbi_pkg::status_t           st_sd  [DW];
	logic [WW-1:0]              w_nx   [DW][2];

	always_comb begin
		logic [rbi_pkg::NMAG_W-1:0] nm;
		rbi_pkg::n_t                nv;
		rbi_pkg::crd_t              dv;
		for (int l = 0; l < 2; l++) begin
			nv = (l == 0) ? req.n0 : req.n1;
			dv = (l == 0) ? req.d0 : req.d1;
			nm = nv[rbi_pkg::N_W-1] ? rbi_pkg::NMAG_W'(-nv) : rbi_pkg::NMAG_W'(nv);
			w_in[l]   = {{RW{1'b0}}, nm, {(FRAC_BITS - 1){1'b0}}};
			dv_in[l]  = dv[rbi_pkg::CRD_W-1] ? rbi_pkg::DMAG_W'(-dv)
			                                 : rbi_pkg::DMAG_W'(dv);
			neg_in[l] = nv[rbi_pkg::N_W-1] ^ dv[rbi_pkg::CRD_W-1];
		end
	end

	// Shift in the next dividend bit, subtract the divisor where it fits.
	always_comb begin
		logic [WW-1:0]              sh;
		logic [rbi_pkg::DMAG_W-1:0] d;
		for (int k = 0; k < DW; k++) begin
			for (int l = 0; l < 2; l++) begin
				sh = (k == 0) ? (w_in[l] << 1) : (w_sd[(k == 0) ? 0 : k - 1][l] << 1);
				d  = (k == 0) ? dv_in[l] : dv_sd[(k == 0) ? 0 : k - 1][l];
				if (sh[WW-1:DW] >= {1'b0, d}) begin
					sh[WW-1:DW] = sh[WW-1:DW] - {1'b0, d};
					sh[0]       = 1'b1;
				end
				w_nx[k][l] = sh;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			st_sd[0] <= req.status;
			for (int l = 0; l < 2; l++) begin
				w_sd[0][l]   <= w_nx[0][l];
				dv_sd[0][l]  <= dv_in[l];
				neg_sd[0][l] <= neg_in[l];
			end
		end
		for (int k = 1; k < DW; k++) begin
			if (en[k]) begin
				st_sd[k] <= st_sd[k-1];
				for (int l = 0; l < 2; l++) begin
					w_sd[k][l]   <= w_nx[k][l];
					dv_sd[k][l]  <= dv_sd[k-1][l];
					neg_sd[k][l] <= neg_sd[k-1][l];
				end
			end
		end
	end

	assign status = st_sd[DW-1];
	assign t0 = neg_sd[DW-1][0] ? -$signed({1'b0, w_sd[DW-1][0][DW-1:0]})
	                            :  $signed({1'b0, w_sd[DW-1][0][DW-1:0]});
	assign t1 = neg_sd[DW-1][1] ? -$signed({1'b0, w_sd[DW-1][1][DW-1:0]})
	                            :  $signed({1'b0, w_sd[DW-1][1][DW-1:0]});

endmodule

### sv/ray_box_intersect.sv
// Top level: configuration registers, stage valid control, sort and clip output stage.
// Throughput: one ray per cycle unless out_ready stalls the output;
// the divider is a pipeline with one quotient bit per stage.
// Every stage has its own valid bit and advances when empty or when its successor advances.
// Reset clears all valid bits and sets edge_x, edge_y and edge_z to 1.0 (65536).
module ray_box_intersect #(
	parameter int FRAC_BITS = rbi_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rbi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rbi_pkg::EDGE_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [rbi_pkg::CRD_W-1:0] ray_x,
	input  logic signed [rbi_pkg::CRD_W-1:0] ray_y,
	input  logic signed [rbi_pkg::CRD_W-1:0] ray_z,
	input  logic signed [rbi_pkg::CRD_W-1:0] dir_x,
	input  logic signed [rbi_pkg::CRD_W-1:0] dir_y,
	input  logic signed [rbi_pkg::CRD_W-1:0] dir_z,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2:0]                      status,
	output logic signed [rbi_pkg::T_W-1:0]  t_near,
	output logic signed [rbi_pkg::T_W-1:0]  t_far,
	output logic                            saturated
);

	localparam int DW   = rbi_pkg::NMAG_W + FRAC_BITS - 1;
	localparam int NSTG = rbi_pkg::FRONT_STAGES + DW + 1;
	localparam int CW   = (DW + 1 > rbi_pkg::T_W) ? DW + 1 : rbi_pkg::T_W;

	localparam logic signed [CW-1:0] TMAX_W = {{(CW - rbi_pkg::T_W + 1){1'b0}},
	                                           {(rbi_pkg::T_W - 1){1'b1}}};
	localparam logic signed [CW-1:0] TMIN_W = {{(CW - rbi_pkg::T_W + 1){1'b1}},
	                                           {(rbi_pkg::T_W - 1){1'b0}}};

	rbi_pkg::edge_t    edge_q [rbi_pkg::NAXES];
	rbi_pkg::crd_t     pos    [rbi_pkg::NAXES];
	rbi_pkg::crd_t     dir    [rbi_pkg::NAXES];
	logic [NSTG-1:0]   v_q;
	logic [NSTG-1:0]   en;
	rbi_pkg::div_req_t req;
	rbi_pkg::status_t  div_status;
	logic signed [DW:0] div_t0;
	logic signed [DW:0] div_t1;

	rbi_pkg::status_t          status_q;
	logic signed [rbi_pkg::T_W-1:0] t_near_q;
	logic signed [rbi_pkg::T_W-1:0] t_far_q;
	logic                      sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q[0] <= rbi_pkg::EDGE_RST;
			edge_q[1] <= rbi_pkg::EDGE_RST;
			edge_q[2] <= rbi_pkg::EDGE_RST;
		end else if (cfg_wr_en) begin
			case (rbi_pkg::reg_idx_t'(cfg_index))
				rbi_pkg::REG_EDGE_X: edge_q[0] <= cfg_data;
				rbi_pkg::REG_EDGE_Y: edge_q[1] <= cfg_data;
				rbi_pkg::REG_EDGE_Z: edge_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage advances when it is empty or its successor advances.
	always_comb begin
		en[NSTG-1] = !v_q[NSTG-1] || out_ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[NSTG-1];

	assign pos[0] = ray_x;
	assign pos[1] = ray_y;
	assign pos[2] = ray_z;
	assign dir[0] = dir_x;
	assign dir[1] = dir_y;
	assign dir[2] = dir_z;

	rbi_front u_front (
		.clk      (clk),
		.en       (en[rbi_pkg::FRONT_STAGES-1:0]),
		.edge_len (edge_q),
		.pos      (pos),
		.dir      (dir),
		.req      (req)
	);

	rbi_div #(
		.FRAC_BITS (FRAC_BITS),
		.DW        (DW)
	) u_div (
		.clk    (clk),
		.en     (en[rbi_pkg::FRONT_STAGES +: DW]),
		.req    (req),
		.status (div_status),
		.t0     (div_t0),
		.t1     (div_t1)
	);

	// Sort on the unclipped values, then clip each to the output range.
	always_ff @(posedge clk) begin
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] b;
		logic signed [CW-1:0] lo;
		logic signed [CW-1:0] hi;
		logic                 s;
		if (en[NSTG-1]) begin
			a  = CW'(div_t0);
			b  = CW'(div_t1);
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
			s  = 1'b0;
			if (lo > TMAX_W) begin
				lo = TMAX_W;
				s  = 1'b1;
			end else if (lo < TMIN_W) begin
				lo = TMIN_W;
				s  = 1'b1;
			end
			if (hi > TMAX_W) begin
				hi = TMAX_W;
				s  = 1'b1;
			end else if (hi < TMIN_W) begin
				hi = TMIN_W;
				s  = 1'b1;
			end
			status_q <= div_status;
			if (div_status == rbi_pkg::ST_HIT) begin
				t_near_q <= lo[rbi_pkg::T_W-1:0];
				t_far_q  <= hi[rbi_pkg::T_W-1:0];
				sat_q    <= s;
			end else begin
				t_near_q <= '0;
				t_far_q  <= '0;
				sat_q    <= 1'b0;
			end
		end
	end

	assign status    = status_q;
	assign t_near    = t_near_q;
	assign t_far     = t_far_q;
	assign saturated = sat_q;

endmodule

### sv/rbi_chk.sv
// Port-level checker for the ray against box block, bound to the top level.
module rbi_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [47:0] t_near,
	input logic [47:0] t_far,
	input logic        saturated
);

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(t_near) && $stable(t_far)
		&& $stable(status))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != rbi_pkg::ST_HIT) |->
		(t_near == '0) && (t_far == '0) && !saturated)
		else $error("non-hit result carries t values");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == rbi_pkg::ST_HIT) |-> $signed(t_near) <= $signed(t_far))
		else $error("near and far out of order");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= rbi_pkg::ST_ZERO_DIR))
		else $error("status code out of range");

endmodule

bind ray_box_intersect rbi_chk u_rbi_chk (.*);
